// ===== design/bu2xq_pkg.sv =====
// Shared types and codes for the 2x bilinear upsampling quad unit.
`timescale 1ns / 1ps

package bu2xq_pkg;

	// Rounding method codes held in the configuration register.
	typedef enum logic [1:0] {
		RND_TREE      = 2'd0,
		RND_HALF_UP   = 2'd1,
		RND_HALF_EVEN = 2'd2,
		RND_DITHER    = 2'd3
	} rnd_method_t;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned NOISE_W = 4;
	// Width of the weighted 9/3/3/1 sum plus the largest rounding offset.
	localparam int unsigned SUM_W   = 12;

	// Input word: one 2x2 source window and its noise value.
	typedef struct packed {
		logic [PIX_W-1:0]   top_left;
		logic [PIX_W-1:0]   top_right;
		logic [PIX_W-1:0]   bottom_left;
		logic [PIX_W-1:0]   bottom_right;
		logic [NOISE_W-1:0] dither_noise;
	} win_t;

	// Output word: the 2x2 block of upsampled pixels.
	typedef struct packed {
		logic [PIX_W-1:0] out_top_left;
		logic [PIX_W-1:0] out_top_right;
		logic [PIX_W-1:0] out_bottom_left;
		logic [PIX_W-1:0] out_bottom_right;
	} quad_t;

endpackage

// ===== design/bu2xq_kernel.sv =====
// One output pixel: 9/3/3/1 weighting of a source window with selectable rounding.
`timescale 1ns / 1ps

module bu2xq_kernel (
	input  logic [bu2xq_pkg::PIX_W-1:0]   center,
	input  logic [bu2xq_pkg::PIX_W-1:0]   edge_a,
	input  logic [bu2xq_pkg::PIX_W-1:0]   edge_b,
	input  logic [bu2xq_pkg::PIX_W-1:0]   diag,
	input  logic [bu2xq_pkg::NOISE_W-1:0] noise,
	input  bu2xq_pkg::rnd_method_t        method,
	output logic [bu2xq_pkg::PIX_W-1:0]   pix
);

	localparam int unsigned PW = bu2xq_pkg::PIX_W;
	localparam int unsigned SW = bu2xq_pkg::SUM_W;

	logic [PW:0]   e_sum;
	logic [PW:0]   cd_sum;
	logic [PW-1:0] lo;
	logic [PW-1:0] hi;
	logic [PW-1:0] cd;
	logic [PW:0]   all_sum;
	logic [PW-1:0] all_avg;
	logic [PW:0]   edge_sum;
	logic [PW-1:0] edge_avg;
	logic [PW:0]   fin_sum;
	logic [PW-1:0] tree_pix;
	logic [SW-1:0] wsum;
	logic [SW-1:0] x_even;
	logic [SW-1:0] rounded;

	// Averaging tree: chained floor and ceil halving averages, all within 8 bits.
	always_comb begin
		e_sum    = {1'b0, edge_a} + {1'b0, edge_b};
		lo       = e_sum[PW:1];
		hi       = PW'((e_sum + (PW+1)'(1)) >> 1);
		cd_sum   = {1'b0, center} + {1'b0, diag} + (PW+1)'(1);
		cd       = cd_sum[PW:1];
		all_sum  = {1'b0, lo} + {1'b0, cd} + (PW+1)'(1);
		all_avg  = all_sum[PW:1];
		edge_sum = {1'b0, hi} + {1'b0, all_avg} + (PW+1)'(1);
		edge_avg = edge_sum[PW:1];
		fin_sum  = {1'b0, center} + {1'b0, edge_avg};
		tree_pix = fin_sum[PW:1];
	end

	// Exact weighted sum; at most 4080, so any rounding offset stays within 12 bits
	// and the quotient never exceeds 255.
	always_comb begin
		wsum = SW'({center, 3'b000}) + SW'(center)
			+ SW'({1'b0, e_sum}) + SW'({e_sum, 1'b0}) + SW'(diag);
		x_even = wsum + SW'(7);
		unique case (method)
			bu2xq_pkg::RND_HALF_UP:   rounded = wsum + SW'(8);
			bu2xq_pkg::RND_HALF_EVEN: rounded = x_even + SW'(x_even[4]);
			bu2xq_pkg::RND_DITHER:    rounded = wsum + SW'(noise);
			default:                  rounded = wsum;
		endcase
	end

	// Method select between the tree and the divided sum.
	assign pix = (method == bu2xq_pkg::RND_TREE) ? tree_pix : rounded[SW-1:4];

endmodule

// ===== design/bu2xq_quad.sv =====
// Four kernels that map one source window onto the 2x2 output block.
`timescale 1ns / 1ps

module bu2xq_quad (
	input  bu2xq_pkg::win_t        win,
	input  bu2xq_pkg::rnd_method_t method,
	output bu2xq_pkg::quad_t       quad
);

	// Each output leans toward its nearest source pixel.
	bu2xq_kernel u_tl (
		.center (win.top_left),
		.edge_a (win.bottom_left),
		.edge_b (win.top_right),
		.diag   (win.bottom_right),
		.noise  (win.dither_noise),
		.method (method),
		.pix    (quad.out_top_left)
	);

	bu2xq_kernel u_tr (
		.center (win.top_right),
		.edge_a (win.top_left),
		.edge_b (win.bottom_right),
		.diag   (win.bottom_left),
		.noise  (win.dither_noise),
		.method (method),
		.pix    (quad.out_top_right)
	);

	bu2xq_kernel u_bl (
		.center (win.bottom_left),
		.edge_a (win.top_left),
		.edge_b (win.bottom_right),
		.diag   (win.top_right),
		.noise  (win.dither_noise),
		.method (method),
		.pix    (quad.out_bottom_left)
	);

	bu2xq_kernel u_br (
		.center (win.bottom_right),
		.edge_a (win.bottom_left),
		.edge_b (win.top_right),
		.diag   (win.top_left),
		.noise  (win.dither_noise),
		.method (method),
		.pix    (quad.out_bottom_right)
	);

endmodule

// ===== design/bilinear_upsample_2x_quad_unit.sv =====
// An accepted window word is captured in the input register, and its quad word in the output register.
// Throughput: one window word per cycle while the output is not stalled; the input register feeds the four kernels,
// whose results land in the output register; the input register can still load while the output register holds.
// A stalled output word holds in its register while an empty input register still takes one more word.
// Reset clears both valid flags and sets the rounding method to the averaging tree.
`timescale 1ns / 1ps

module bilinear_upsample_2x_quad_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	// Window input channel.
	input  logic                  win_valid,
	output logic                  win_stall,
	input  bu2xq_pkg::win_t       win,
	// Quad output channel.
	output logic                  quad_valid,
	input  logic                  quad_stall,
	output bu2xq_pkg::quad_t      quad,
	// Configuration write channel.
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_data
);

	bu2xq_pkg::rnd_method_t method_q;
	logic                   valid_s1;
	bu2xq_pkg::win_t        win_s1;
	logic                   valid_s2;
	bu2xq_pkg::quad_t       quad_s2;
	bu2xq_pkg::quad_t       quad_comb;
	logic                   load_s2;
	logic                   load_s1;

	// Configuration register; always ready.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q <= bu2xq_pkg::RND_TREE;
		end else if (cfg_valid && cfg_ready) begin
			method_q <= bu2xq_pkg::rnd_method_t'(cfg_data);
		end
	end

	// Pipeline flow: output register loads when empty or drained, input register
	// loads when empty or when its word moves on.
	assign load_s2   = !valid_s2 || !quad_stall;
	assign load_s1   = !valid_s1 || load_s2;
	assign win_stall = !load_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (load_s1) begin
				valid_s1 <= win_valid;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (load_s1 && win_valid) begin
			win_s1 <= win;
		end
		if (load_s2 && valid_s1) begin
			quad_s2 <= quad_comb;
		end
	end

	// Kernel logic between the two registers.
	bu2xq_quad u_quad (
		.win    (win_s1),
		.method (method_q),
		.quad   (quad_comb)
	);

	assign quad_valid = valid_s2;
	assign quad       = quad_s2;

endmodule
